// ----- sv/xsa_pkg.sv -----
// Shared types, constants and the one-step generator function for the skip-ahead block.
package xsa_pkg;

    localparam int WORD_W    = 32;
    localparam int COLS      = 32;
    localparam int IDX_W     = 5;
    localparam int SHIFT_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] MASK31 = 32'h7fff_ffff;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VARIANT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_C = 2'd3;

    // variant codes
    localparam logic VARIANT_RLR31 = 1'b0;
    localparam logic VARIANT_LRL   = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

    // one generator step; wmask trims the wide variant to the state width
    function automatic word_t gen_step(
        input word_t              x_in,
        input logic               variant,
        input logic [SHIFT_W-1:0] sa,
        input logic [SHIFT_W-1:0] sb,
        input logic [SHIFT_W-1:0] sc,
        input word_t              wmask
    );
        word_t x;
        x = x_in;
        if (variant == VARIANT_RLR31) begin
            x = x & MASK31;
            x = x ^ (x >> sa);
            x = x ^ (x << sb);
            x = x & MASK31;
            x = x ^ (x >> sc);
        end else begin
            x = x & wmask;
            x = x ^ (x << sa);
            x = x & wmask;
            x = x ^ (x >> sb);
            x = x ^ (x << sc);
            x = x & wmask;
        end
        return x;
    endfunction

endpackage

// ----- sv/xsa_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered read data.
module xsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/xsa_gf2_unit.sv -----
// Column copy of the GF(2) matrix and its combinational matrix-vector product.
module xsa_gf2_unit (
    input  logic                aclk,
    input  logic                shift_en,
    input  xsa_pkg::word_t      col_in,
    input  xsa_pkg::word_t      vec_in,
    output xsa_pkg::word_t      product
);

    xsa_pkg::word_t cols_reg [xsa_pkg::COLS];

    // shift columns in from the top; after COLS shifts column j sits in lane j
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            for (int k = 0; k < xsa_pkg::COLS - 1; k++) begin
                cols_reg[k] <= cols_reg[k+1];
            end
            cols_reg[xsa_pkg::COLS-1] <= col_in;
        end
    end

    // each lane adds its column where the vector bit is set
    always_comb begin
        product = '0;
        for (int k = 0; k < xsa_pkg::COLS; k++) begin
            if (vec_in[k]) begin
                product = product ^ cols_reg[k];
            end
        end
    end

endmodule

// ----- sv/xorshift_skip_ahead.sv -----
// Top level of the xorshift skip-ahead block: sequencer, matrix RAM, vector accumulator.
// Flow: build the one-step matrix, then for each count bit up to the highest set one update the
//   vector and, but for that last bit, square the matrix; a zero count gives the masked seed.
// Throughput: one item at a time; the matrix RAM read port moves one column per cycle and
//   each count bit but the last reads the 32 columns twice (vector update, then squaring).
// Reset: aresetn, synchronous and active low, returns to idle with no result pending and
//   loads the register defaults (variant 1, shifts 13, 17, 5); the RAM is not cleared.
module xorshift_skip_ahead #(
    parameter int STATE_BITS = 32,
    parameter int COUNT_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [63:0]                     s_tdata,   // seed [31:0], skip_count [63:32]
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // jumped_state [31:0]
    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [xsa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [xsa_pkg::SHIFT_W-1:0]     cfg_data
);

    // count bits that can matter: the input field is 32 bits wide
    localparam int CNT_W = (COUNT_BITS < 32) ? COUNT_BITS : 32;
    localparam logic [31:0] WIDE_MASK =
        (STATE_BITS >= 32) ? 32'hffff_ffff : 32'((64'd1 << STATE_BITS) - 64'd1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUILD,   // write the one-step matrix, one column a cycle
        ST_LOAD,    // stream columns into the copy and update the vector
        ST_SQUARE,  // square the matrix column by column, in place
        ST_DONE     // hand the vector to the output register
    } state_t;

    state_t                       state_reg, state_next;
    logic [xsa_pkg::IDX_W:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    xsa_pkg::word_t               vec_reg, vec_next;
    xsa_pkg::word_t               acc_reg, acc_next;
    logic                         m_tvalid_reg, m_tvalid_next;
    xsa_pkg::word_t               m_tdata_reg, m_tdata_next;

    logic                         variant_reg, variant_next;
    logic [xsa_pkg::SHIFT_W-1:0]  shift_a_reg, shift_a_next;
    logic [xsa_pkg::SHIFT_W-1:0]  shift_b_reg, shift_b_next;
    logic [xsa_pkg::SHIFT_W-1:0]  shift_c_reg, shift_c_next;

    // matrix RAM ports
    logic                         ram_we;
    logic [xsa_pkg::IDX_W-1:0]    ram_waddr;
    xsa_pkg::word_t               ram_wdata;
    logic                         ram_re;
    logic [xsa_pkg::IDX_W-1:0]    ram_raddr;
    xsa_pkg::word_t               ram_rdata;

    logic                         copy_shift;
    xsa_pkg::word_t               product;

    logic [xsa_pkg::IDX_W-1:0]    col_idx;
    logic [xsa_pkg::IDX_W-1:0]    arr_idx;
    logic                         last_col;
    xsa_pkg::word_t               vmask;
    xsa_pkg::word_t               acc_term;
    logic [CNT_W-1:0]             in_count;

    assign col_idx  = cnt_reg[xsa_pkg::IDX_W-1:0];
    // read data of the previous cycle's address; wraps to the last column at the end
    assign arr_idx  = xsa_pkg::IDX_W'(cnt_reg - 1'b1);
    assign last_col = cnt_reg[xsa_pkg::IDX_W];
    assign vmask    = (variant_reg == xsa_pkg::VARIANT_RLR31) ? xsa_pkg::MASK31 : WIDE_MASK;
    assign in_count = s_tdata[32 +: CNT_W];
    assign acc_term = vec_reg[arr_idx] ? ram_rdata : '0;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    xsa_ram #(
        .WIDTH (xsa_pkg::WORD_W),
        .DEPTH (xsa_pkg::COLS)
    ) u_matrix_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    xsa_gf2_unit u_gf2 (
        .aclk     (aclk),
        .shift_en (copy_shift),
        .col_in   (ram_rdata),
        .vec_in   (ram_rdata),
        .product  (product)
    );

    // RAM and copy control, decoded from the phase
    always_comb begin
        ram_we     = 1'b0;
        ram_waddr  = col_idx;
        ram_wdata  = product;
        ram_re     = 1'b0;
        ram_raddr  = col_idx;
        copy_shift = 1'b0;
        case (state_reg)
            ST_BUILD: begin
                // column i is one step applied to unit vector i
                ram_we    = 1'b1;
                ram_wdata = xsa_pkg::gen_step(xsa_pkg::word_t'(1) << col_idx, variant_reg,
                                              shift_a_reg, shift_b_reg, shift_c_reg,
                                              WIDE_MASK);
            end
            ST_LOAD: begin
                ram_re     = !last_col;
                copy_shift = (cnt_reg != '0);
            end
            ST_SQUARE: begin
                // read column i, write squared column i-1 back in its place
                ram_re    = !last_col;
                ram_we    = (cnt_reg != '0);
                ram_waddr = arr_idx;
            end
            default: begin
            end
        endcase
    end

    // sequencer and register updates
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        count_next    = count_reg;
        vec_next      = vec_reg;
        acc_next      = acc_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        variant_next  = variant_reg;
        shift_a_next  = shift_a_reg;
        shift_b_next  = shift_b_reg;
        shift_c_next  = shift_c_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                xsa_pkg::REG_VARIANT: variant_next = cfg_data[0];
                xsa_pkg::REG_SHIFT_A: shift_a_next = cfg_data;
                xsa_pkg::REG_SHIFT_B: shift_b_next = cfg_data;
                xsa_pkg::REG_SHIFT_C: shift_c_next = cfg_data;
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    vec_next   = s_tdata[31:0] & vmask;
                    count_next = in_count;
                    cnt_next   = '0;
                    acc_next   = '0;
                    // a zero count returns the masked seed untouched
                    state_next = (in_count == '0) ? ST_DONE : ST_BUILD;
                end
            end
            ST_BUILD: begin
                cnt_next = cnt_reg + 1'b1;
                if (col_idx == xsa_pkg::IDX_W'(xsa_pkg::COLS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    acc_next = acc_reg ^ acc_term;
                end
                if (last_col) begin
                    // last column is in: apply the power if this count bit is set
                    if (count_reg[0]) begin
                        vec_next = acc_reg ^ acc_term;
                    end
                    count_next = count_reg >> 1;
                    cnt_next   = '0;
                    acc_next   = '0;
                    state_next = ((count_reg >> 1) == '0) ? ST_DONE : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                cnt_next = cnt_reg + 1'b1;
                if (last_col) begin
                    cnt_next   = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = vec_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            variant_reg  <= xsa_pkg::VARIANT_LRL;
            shift_a_reg  <= 5'd13;
            shift_b_reg  <= 5'd17;
            shift_c_reg  <= 5'd5;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
            variant_reg  <= variant_next;
            shift_a_reg  <= shift_a_next;
            shift_b_reg  <= shift_b_next;
            shift_c_reg  <= shift_c_next;
        end
        count_reg   <= count_next;
        vec_reg     <= vec_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    // the in-place squaring never reads and writes one column in the same cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("matrix RAM read and write hit the same column");

    // no matrix work runs once the count is used up
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD || state_reg == ST_SQUARE) |-> (count_reg != '0))
        else $error("matrix pass with an empty count");

    // an accepted item closes the input until its result is handed over
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after an accept");

    // a result appears only out of the hand-over state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside hand-over");

endmodule

// ----- tb/sv/xorshift_skip_ahead_test.sv -----
// Self-checking testbench for xorshift_skip_ahead: directed and random jumps against a GF(2) predictor.
`timescale 1ns / 1ps

module xorshift_skip_ahead_test;

    localparam int HOLD_CYCLES  = 6000;  // long result hold, well past the slowest jump
    localparam int TAIL_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 67;
    localparam int MAX_REPORTS  = 40;

    // columns of the step matrix, packed so tasks and functions take it by value
    typedef logic [xsa_pkg::COLS-1:0][xsa_pkg::WORD_W-1:0] mat_t;

    typedef struct packed {
        xsa_pkg::word_t seed;
        xsa_pkg::word_t count;
        xsa_pkg::word_t state;
    } jump_t;

    typedef enum int {RDY_FULL, RDY_MOSTLY, RDY_SPARSE, RDY_TOGGLE} ready_mode_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [63:0]                   s_tdata   = '0;   // seed [31:0], skip_count [63:32]
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [31:0]                   m_tdata;          // jumped_state [31:0]
    logic                          cfg_wr_en = 1'b0;
    logic [xsa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [xsa_pkg::SHIFT_W-1:0]   cfg_data  = '0;

    // shadow of the register file, reset values
    logic                        cur_variant = xsa_pkg::VARIANT_LRL;
    logic [xsa_pkg::SHIFT_W-1:0] cur_sa      = 5'd13;
    logic [xsa_pkg::SHIFT_W-1:0] cur_sb      = 5'd17;
    logic [xsa_pkg::SHIFT_W-1:0] cur_sc      = 5'd5;

    jump_t       pending_jumps[$];
    int unsigned error_count    = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned settings_used  = 1;
    int unsigned burst_left     = 0;

    // receiver stall pattern and long hold
    ready_mode_t ready_mode = RDY_FULL;
    int unsigned mode_left  = 0;
    int unsigned hold_left  = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_taken = 0;

    xorshift_skip_ahead u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // ---------------------------------------------------------------- predictor

    // one generator step under the shadow configuration
    function automatic xsa_pkg::word_t advance_once(input xsa_pkg::word_t x);
        xsa_pkg::word_t v = x;
        if (cur_variant == xsa_pkg::VARIANT_RLR31) begin
            v = v & xsa_pkg::MASK31;
            v = v ^ (v >> cur_sa);
            v = v ^ (v << cur_sb);
            v = v & xsa_pkg::MASK31;
            v = v ^ (v >> cur_sc);
        end else begin
            // full 32-bit state: no trimming needed
            v = v ^ (v << cur_sa);
            v = v ^ (v >> cur_sb);
            v = v ^ (v << cur_sc);
        end
        return v;
    endfunction

    // matrix times vector over GF(2): xor of the columns picked by the set bits
    function automatic xsa_pkg::word_t apply_cols(input mat_t m, input xsa_pkg::word_t v);
        xsa_pkg::word_t acc = '0;
        for (int i = 0; i < xsa_pkg::COLS; i++) begin
            if (v[i])
                acc = acc ^ m[i];
        end
        return acc;
    endfunction

    // state after count steps, by square-and-multiply from the low count bit up
    function automatic xsa_pkg::word_t jump_state(input xsa_pkg::word_t seed,
                                                  input xsa_pkg::word_t count);
        mat_t           cols;
        mat_t           squared;
        xsa_pkg::word_t acc;
        xsa_pkg::word_t left;
        int             width;
        width = (cur_variant == xsa_pkg::VARIANT_RLR31) ? 31 : xsa_pkg::WORD_W;
        for (int i = 0; i < xsa_pkg::COLS; i++)
            cols[i] = (i < width) ? advance_once(xsa_pkg::word_t'(1) << i) : '0;
        acc  = (cur_variant == xsa_pkg::VARIANT_RLR31) ? (seed & xsa_pkg::MASK31) : seed;
        left = count;
        while (left != '0) begin
            if (left[0])
                acc = apply_cols(cols, acc);
            left = left >> 1;
            for (int i = 0; i < xsa_pkg::COLS; i++)
                squared[i] = apply_cols(cols, cols[i]);
            cols = squared;
        end
        return acc;
    endfunction

    // ---------------------------------------------------------------- helpers

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // offer one item; hold tvalid across a burst, drop it and idle between bursts
    task automatic send_item(input xsa_pkg::word_t seed, input xsa_pkg::word_t count);
        jump_t j;
        s_tvalid <= 1'b1;
        s_tdata  <= {count, seed};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        j.seed  = seed;
        j.count = count;
        j.state = jump_state(seed, count);
        pending_jumps.push_back(j);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // drain: stop offering, wait for every expected state, then let the block settle
    task automatic wait_idle();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        while (pending_jumps.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [xsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [xsa_pkg::SHIFT_W-1:0]   val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    // only call while idle; variant rides in bit 0 with junk above it
    task automatic set_config(input logic v, input logic [xsa_pkg::SHIFT_W-1:0] a,
                              input logic [xsa_pkg::SHIFT_W-1:0] b,
                              input logic [xsa_pkg::SHIFT_W-1:0] c);
        write_reg(xsa_pkg::REG_VARIANT, {4'($urandom_range(0, 15)), v});
        write_reg(xsa_pkg::REG_SHIFT_A, a);
        write_reg(xsa_pkg::REG_SHIFT_B, b);
        write_reg(xsa_pkg::REG_SHIFT_C, c);
        cfg_wr_en   <= 1'b0;
        cur_variant = v;
        cur_sa      = a;
        cur_sb      = b;
        cur_sc      = c;
        settings_used++;
    endtask

    function automatic xsa_pkg::word_t pick_seed();
        case ($urandom_range(0, 9))
            0:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
            1:       return xsa_pkg::word_t'(1) << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // mostly short counts keep the run fast; some reach the full 32 bits
    function automatic xsa_pkg::word_t pick_count();
        int             width;
        xsa_pkg::word_t c;
        width = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 10) : $urandom_range(0, 32);
        if (width == 0)
            return '0;
        c = $urandom;
        if (width < 32)
            c = c & ((xsa_pkg::word_t'(1) << width) - 1);
        if ($urandom_range(0, 1) == 1)
            c[width-1] = 1'b1;
        return c;
    endfunction

    function automatic logic [xsa_pkg::SHIFT_W-1:0] pick_shift();
        return ($urandom_range(0, 15) == 0) ? '0 : xsa_pkg::SHIFT_W'($urandom_range(1, 31));
    endfunction

    // ---------------------------------------------------------------- receiver

    // stall pattern changes at random intervals; a requested hold overrides it
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            ready_mode <= ready_mode_t'($urandom_range(0, 3));
            mode_left  <= $urandom_range(16, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (hold_taken != hold_asked) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            case (ready_mode)
                RDY_FULL:   m_tready <= 1'b1;
                RDY_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                RDY_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:    m_tready <= ~m_tready;
            endcase
        end
    end

    // compare each accepted result with the oldest expected state
    always @(posedge aclk) begin : check_results
        jump_t j;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_jumps.size() == 0) begin
                report_error($sformatf("result %h with nothing expected", m_tdata));
            end else begin
                j = pending_jumps.pop_front();
                results_seen++;
                if (m_tdata !== j.state)
                    report_error($sformatf("seed %h count %h: got %h, want %h",
                                           j.seed, j.count, m_tdata, j.state));
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // reset values: wide step, shifts 13/17/5
    task automatic test_reset_config();
        send_item(32'h0000_0000, 32'h0000_0005);  // zero seed is a fixed point
        send_item(32'hffff_ffff, 32'h0000_0000);  // zero count returns the seed
        send_item(32'h1234_5678, 32'h0000_0000);
        send_item(32'h0000_0001, 32'h0000_0001);
        send_item(32'h8000_0000, 32'h0000_0001);
        send_item(32'hdead_beef, 32'hffff_ffff);  // every count bit set
        send_item(32'hffff_ffff, 32'h8000_0000);  // only the top count bit
        send_item(32'h0000_0001, 32'h5555_5555);
        send_item(32'hcafe_f00d, 32'h0000_0002);
        wait_idle();
    endtask

    // 31-bit step: bit 31 of the seed must be cleared, even with a zero count
    task automatic test_narrow_step();
        set_config(xsa_pkg::VARIANT_RLR31, 5'd7, 5'd11, 5'd3);
        send_item(32'hffff_ffff, 32'h0000_0000);
        send_item(32'h8000_0000, 32'h0000_0001);
        send_item(32'h7fff_ffff, 32'hffff_ffff);
        send_item(32'hffff_fffe, 32'h0000_0003);
        wait_idle();
    endtask

    // a zero shift wipes the state on the first step
    task automatic test_zero_shift();
        set_config(xsa_pkg::VARIANT_LRL, 5'd0, 5'd17, 5'd5);
        send_item(32'hffff_ffff, 32'h0000_0001);
        send_item(32'h0000_1234, 32'h0000_0000);
        wait_idle();
        set_config(xsa_pkg::VARIANT_RLR31, 5'd3, 5'd5, 5'd0);
        send_item(32'h7654_3210, 32'h0000_0007);
        send_item(32'hffff_ffff, 32'h0000_0000);
        wait_idle();
    endtask

    // largest nonzero shifts in the wide variant, smallest nonzero shifts in the 31-bit variant
    task automatic test_shift_extremes();
        set_config(xsa_pkg::VARIANT_LRL, 5'd31, 5'd31, 5'd31);
        send_item(32'hffff_ffff, 32'h0000_00ff);
        send_item(32'h0000_0001, 32'hffff_ffff);
        wait_idle();
        set_config(xsa_pkg::VARIANT_RLR31, 5'd1, 5'd1, 5'd1);
        send_item(32'hffff_ffff, 32'h0000_00ff);
        send_item(32'h4000_0001, 32'hffff_ffff);
        wait_idle();
    endtask

    // random items under a series of settings: the reset values, then the extremes, then random ones
    task automatic test_random_settings();
        for (int p = 0; p < 8; p++) begin
            case (p)
                0:       set_config(xsa_pkg::VARIANT_LRL, 5'd13, 5'd17, 5'd5);
                1:       set_config(xsa_pkg::VARIANT_RLR31, 5'd31, 5'd31, 5'd31);
                2:       set_config(xsa_pkg::VARIANT_LRL, 5'd1, 5'd1, 5'd1);
                default: set_config(1'($urandom_range(0, 1)), pick_shift(), pick_shift(),
                                    pick_shift());
            endcase
            repeat (PHASE_ITEMS)
                send_item(pick_seed(), pick_count());
            wait_idle();
        end
    endtask

    // hold the result side long enough that the block backs up into its input
    task automatic test_result_hold();
        set_config(xsa_pkg::VARIANT_LRL, 5'd13, 5'd17, 5'd5);
        hold_asked <= hold_asked + 1;
        repeat (6)
            send_item(pick_seed(), xsa_pkg::word_t'($urandom_range(64, 511)));
        wait_idle();
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_config();
        test_narrow_step();
        test_zero_shift();
        test_shift_extremes();
        test_result_hold();
        test_random_settings();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Sent %0d items and checked %0d results over %0d register settings.",
                 items_sent, results_seen, settings_used);
        $display("Covered zero and full-width counts, both step variants, zero and edge shifts.");
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", error_count);
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #12_000_000;
        $display("Timeout with %0d results outstanding", pending_jumps.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
